[sv/mix_minus_audio_mixer_defines.svh]
// Shared assertion macros for the mixer RTL.
`ifndef MIX_MINUS_AUDIO_MIXER_DEFINES_SVH
`define MIX_MINUS_AUDIO_MIXER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MMIX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("mixer check failed: same-cycle implication");

// Next-cycle implication, checked on every rising edge outside reset.
`define MMIX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("mixer check failed: next-cycle implication");

`endif

[sv/mmix_pkg.sv]
package mmix_pkg;

	localparam int MAX_LANES         = 8;
	localparam int SPEAKER_LANES_DEF = 8;

	localparam logic signed [15:0] SAT_HIGH = 16'sh7FFF;
	localparam logic signed [15:0] SAT_LOW  = 16'sh8000;

	typedef struct packed {
		logic signed [15:0] voice_0;
		logic signed [15:0] voice_1;
		logic signed [15:0] voice_2;
		logic signed [15:0] voice_3;
		logic signed [15:0] voice_4;
		logic signed [15:0] voice_5;
		logic signed [15:0] voice_6;
		logic signed [15:0] voice_7;
		logic [7:0]         active_mask;
	} voice_word_t;

	typedef struct packed {
		logic signed [15:0] listener_mix;
		logic signed [15:0] minus_0;
		logic signed [15:0] minus_1;
		logic signed [15:0] minus_2;
		logic signed [15:0] minus_3;
		logic signed [15:0] minus_4;
		logic signed [15:0] minus_5;
		logic signed [15:0] minus_6;
		logic signed [15:0] minus_7;
	} mix_word_t;

	// Clamp a 17-bit sum to the 16-bit range.
	function automatic logic signed [15:0] sat16(input logic [16:0] s);
		if (s[16] != s[15]) begin
			return s[16] ? SAT_LOW : SAT_HIGH;
		end
		return s[15:0];
	endfunction

	function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
			input logic signed [15:0] b);
		logic [16:0] s;
		s = {a[15], a} + {b[15], b};
		return sat16(s);
	endfunction

	function automatic logic signed [15:0] sat_sub(input logic signed [15:0] a,
			input logic signed [15:0] b);
		logic [16:0] s;
		s = {a[15], a} - {b[15], b};
		return sat16(s);
	endfunction

endpackage

[sv/mmix_voice_if.sv]
interface mmix_voice_if;
	logic                valid;
	logic                ready;
	mmix_pkg::voice_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/mmix_mix_if.sv]
interface mmix_mix_if;
	logic              valid;
	logic              ready;
	mmix_pkg::mix_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/mix_minus_audio_mixer.sv]
// Mix-minus conference mixer: each word on samples carries one sample position for up to
// eight speaker lanes and a mask of who is speaking; each word on mixes carries the
// saturated listener mix and, per lane, that mix with the lane's own voice removed.
// The block takes one word every clock cycle while mixes does not stall, and returns each
// result through the input register, then the result register; the mixing itself is a
// single combinational pass between those two registers. Backpressure on mixes stalls both
// stages, and samples stays ready while either stage has room. SPEAKER_LANES limits
// how many lanes take part; mask bits of higher lanes are ignored.
`include "mix_minus_audio_mixer_defines.svh"

module mix_minus_audio_mixer #(
	parameter int SPEAKER_LANES = mmix_pkg::SPEAKER_LANES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	mmix_voice_if.sink    samples,
	mmix_mix_if.source    mixes
);
	import mmix_pkg::*;

	// Pipeline occupancy.
	logic        v_s1;
	logic        v_s2;
	// Stage advance enables: a stage loads when it is empty or its word leaves.
	logic        adv_s1;
	logic        adv_s2;

	voice_word_t word_s1;
	mix_word_t   mix_comb;
	mix_word_t   word_s2;

	assign adv_s2 = !v_s2 || mixes.ready;
	assign adv_s1 = !v_s1 || adv_s2;

	assign samples.ready = adv_s1;
	assign mixes.valid   = v_s2;
	assign mixes.data    = word_s2;

	// Advance the valid bits; hold them while the downstream side stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= samples.valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Capture the accepted word.
	always_ff @(posedge clk) begin
		if (samples.valid && adv_s1) begin
			word_s1 <= samples.data;
		end
	end

	mmix_core #(
		.SpeakerLanes (SPEAKER_LANES)
	) u_core (
		.samples_word (word_s1),
		.mix_word     (mix_comb)
	);

	// Register the mix result; hold it while mixes is stalled.
	always_ff @(posedge clk) begin
		if (v_s1 && adv_s2) begin
			word_s2 <= mix_comb;
		end
	end

	// An empty input stage always has room for a new word.
	`MMIX_ASSERT_NOW(a_in_room, clk, arst_n, !v_s1, samples.ready)
	// A word in the input stage moves into an empty result register next cycle.
	`MMIX_ASSERT_NEXT(a_move_on, clk, arst_n, v_s1 && !v_s2, v_s2)
	// A result only appears when the input stage held a word.
	`MMIX_ASSERT_NOW(a_from_s1, clk, arst_n, $rose(v_s2), $past(v_s1))
	// Silent lanes hear the plain listener mix.
	`MMIX_ASSERT_NOW(a_lane0_idle, clk, arst_n, v_s1 && !word_s1.active_mask[0],
		mix_comb.minus_0 == mix_comb.listener_mix)
	`MMIX_ASSERT_NOW(a_lane7_idle, clk, arst_n, v_s1 && !word_s1.active_mask[7],
		mix_comb.minus_7 == mix_comb.listener_mix)

endmodule

[sv/mmix_core.sv]
module mmix_core #(
	parameter int SpeakerLanes = mmix_pkg::SPEAKER_LANES_DEF
) (
	input  mmix_pkg::voice_word_t samples_word,
	output mmix_pkg::mix_word_t   mix_word
);
	import mmix_pkg::*;

	localparam logic [MAX_LANES-1:0] LaneMask = MAX_LANES'((1 << SpeakerLanes) - 1);

	logic signed [15:0] voice [MAX_LANES];
	logic signed [15:0] minus [MAX_LANES];
	logic signed [15:0] mix;
	logic [MAX_LANES-1:0] act;

	assign voice[0] = samples_word.voice_0;
	assign voice[1] = samples_word.voice_1;
	assign voice[2] = samples_word.voice_2;
	assign voice[3] = samples_word.voice_3;
	assign voice[4] = samples_word.voice_4;
	assign voice[5] = samples_word.voice_5;
	assign voice[6] = samples_word.voice_6;
	assign voice[7] = samples_word.voice_7;

	// Lanes past the configured count never speak.
	assign act = samples_word.active_mask & LaneMask;

	// Running sum in ascending lane order, clamped after every add.
	always_comb begin
		mix = '0;
		for (int k = 0; k < MAX_LANES; k++) begin
			if (act[k]) begin
				mix = sat_add(mix, voice[k]);
			end
		end
	end

	always_comb begin
		for (int k = 0; k < MAX_LANES; k++) begin
			minus[k] = act[k] ? sat_sub(mix, voice[k]) : mix;
		end
	end

	assign mix_word.listener_mix = mix;
	assign mix_word.minus_0      = minus[0];
	assign mix_word.minus_1      = minus[1];
	assign mix_word.minus_2      = minus[2];
	assign mix_word.minus_3      = minus[3];
	assign mix_word.minus_4      = minus[4];
	assign mix_word.minus_5      = minus[5];
	assign mix_word.minus_6      = minus[6];
	assign mix_word.minus_7      = minus[7];

endmodule

[test/mix_minus_audio_mixer_tb.sv]
`timescale 1ns / 1ps

// Testbench for the mix-minus conference mixer.
//
// Every sample word accepted on the samples channel is turned into the mix word that the
// block must return. The predicted word waits in a queue, and each word accepted on the
// mixes channel is compared with the oldest one, field by field. The block keeps no state
// between words and has no configuration registers, so one predictor call per sample word
// covers the whole behavior.
//
// Inputs change on the falling edge. Both handshakes are observed on the rising edge,
// where the values of the previous half cycle are still in place.
module mix_minus_audio_mixer_tb;
	import mmix_pkg::*;

	localparam int LANES = SPEAKER_LANES_DEF;
	localparam int RANDOM_WORDS = 1130;

	// Holds the mix words still owed by the block and checks the ones that arrive.
	class mix_scoreboard;
		mix_word_t expected_q[$];
		int lanes;
		int words_in;
		int words_checked;
		int failures;

		function new(int lanes);
			this.lanes = lanes;
		endfunction

		function int clamp16(int v);
			if (v > int'(SAT_HIGH)) return int'(SAT_HIGH);
			if (v < int'(SAT_LOW)) return int'(SAT_LOW);
			return v;
		endfunction

		// Sum the active voices in ascending lane order, clipping after every
		// addition, then take each active lane's own voice back out.
		function mix_word_t predict_mix(voice_word_t w);
			logic signed [15:0] voice [8];
			logic signed [15:0] minus [8];
			int mix;
			voice = '{w.voice_0, w.voice_1, w.voice_2, w.voice_3,
				w.voice_4, w.voice_5, w.voice_6, w.voice_7};
			mix = 0;
			for (int k = 0; k < 8; k++) begin
				if (k < lanes && w.active_mask[k]) begin
					mix = clamp16(mix + voice[k]);
				end
			end
			for (int k = 0; k < 8; k++) begin
				if (k < lanes && w.active_mask[k]) begin
					minus[k] = 16'(clamp16(mix - voice[k]));
				end else begin
					minus[k] = 16'(mix);
				end
			end
			return '{16'(mix), minus[0], minus[1], minus[2], minus[3],
				minus[4], minus[5], minus[6], minus[7]};
		endfunction

		function void flag(string what);
			failures++;
			if (failures <= 10) begin
				$display("ERROR: %s", what);
			end
		endfunction

		function void note_samples(voice_word_t w);
			expected_q.push_back(predict_mix(w));
			words_in++;
		endfunction

		function void check_mix(mix_word_t got);
			mix_word_t want;
			logic [16*9-1:0] got_bits;
			logic [16*9-1:0] want_bits;
			if (expected_q.size() == 0) begin
				flag($sformatf("mix word %h arrived with nothing outstanding", got));
				return;
			end
			want = expected_q.pop_front();
			got_bits = got;
			want_bits = want;
			for (int f = 0; f < 9; f++) begin
				if (got_bits[(8 - f) * 16 +: 16] !== want_bits[(8 - f) * 16 +: 16]) begin
					flag($sformatf("mix word %0d, %s: expected %0d, got %0d",
						words_checked,
						f == 0 ? "listener_mix" : $sformatf("minus_%0d", f - 1),
						$signed(want_bits[(8 - f) * 16 +: 16]),
						$signed(got_bits[(8 - f) * 16 +: 16])));
				end
			end
			words_checked++;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit steady;

	mmix_voice_if samples();
	mmix_mix_if mixes();

	mix_scoreboard board = new(LANES);

	mix_minus_audio_mixer #(
		.SPEAKER_LANES(LANES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples),
		.mixes(mixes)
	);

	always #2 clk = ~clk;

	// Watch both channels on the rising edge; note a sample word before checking a mix
	// word so that a block returning the mix in the cycle of acceptance would still line up.
	always @(posedge clk) begin
		if (arst_n) begin
			if (samples.valid && samples.ready) begin
				board.note_samples(samples.data);
			end
			if (mixes.valid && mixes.ready) begin
				board.check_mix(mixes.data);
			end
		end
	end

	// Draw a random idle gap before each word, or none while a steady stretch runs.
	function automatic int draw_gap();
		return steady ? 0 : $urandom_range(0, 9);
	endfunction

	// Favor the rails and quiet talkers so that clipping and near-zero sums both show up.
	function automatic logic signed [15:0] draw_voice();
		case ($urandom_range(0, 7))
			0: return SAT_HIGH;
			1: return SAT_LOW;
			2: return 16'(int'($urandom_range(0, 400)) - 200);
			default: return 16'($urandom);
		endcase
	endfunction

	// Mix in full conferences, silent ones and lone speakers with arbitrary masks.
	function automatic logic [7:0] draw_mask();
		case ($urandom_range(0, 5))
			0: return 8'hFF;
			1: return 8'h00;
			2: return 8'(1 << $urandom_range(0, 7));
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic voice_word_t pack_word(logic [7:0] mask, logic signed [15:0] v [8]);
		return '{v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], mask};
	endfunction

	// Drive one sample word: idle first, then hold it until the block takes it.
	// Entered and left on a falling edge.
	task automatic send_word(input voice_word_t w);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			samples.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		samples.data = w;
		samples.valid = 1'b1;
		do @(posedge clk); while (!samples.ready);
		@(negedge clk);
	endtask

	// Stall the mixes channel before each word, then hold ready until one is taken.
	task automatic run_sink();
		int stall;
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				mixes.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			mixes.ready = 1'b1;
			do @(posedge clk); while (!mixes.valid);
			@(negedge clk);
		end
	endtask

	initial begin
		logic signed [15:0] lanes [8];
		voice_word_t w;

		clk = 1'b0;
		arst_n = 1'b0;
		steady = 1'b0;
		samples.valid = 1'b0;
		samples.data = '0;
		mixes.ready = 1'b0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		fork
			run_sink();
		join_none

		// Nobody speaking: loud voices must not leak into any output.
		lanes = '{default: SAT_HIGH};
		send_word(pack_word(8'h00, lanes));
		lanes = '{default: SAT_LOW};
		send_word(pack_word(8'h00, lanes));

		// Everyone at a rail: the mix pins and every minus lands on zero; then everyone at zero.
		lanes = '{default: SAT_HIGH};
		send_word(pack_word(8'hFF, lanes));
		lanes = '{default: SAT_LOW};
		send_word(pack_word(8'hFF, lanes));
		lanes = '{default: 16'sd0};
		send_word(pack_word(8'hFF, lanes));

		// Clip early, then pull back: lane order decides the mix, and some minus values clip too.
		lanes = '{SAT_HIGH, SAT_HIGH, SAT_LOW, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
		send_word(pack_word(8'h07, lanes));
		lanes = '{SAT_LOW, SAT_LOW, SAT_HIGH, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
		send_word(pack_word(8'h07, lanes));
		lanes = '{SAT_HIGH, SAT_HIGH, SAT_HIGH, SAT_HIGH, SAT_LOW, SAT_LOW, 16'sd5,
			-16'sd5};
		send_word(pack_word(8'hFF, lanes));

		// One speaker at a time at the negative rail, with loud silent neighbors.
		for (int k = 0; k < 8; k++) begin
			lanes = '{default: SAT_HIGH};
			lanes[k] = SAT_LOW;
			send_word(pack_word(8'(1 << k), lanes));
		end

		// Alternating masks and bit patterns.
		lanes = '{default: 16'sh5555};
		send_word(pack_word(8'hAA, lanes));
		lanes = '{default: -16'sh5556};
		send_word(pack_word(8'h55, lanes));
		lanes = '{16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'sd1, -16'sd1};
		send_word(pack_word(8'hFF, lanes));

		// Random part: switch between idling and steady stretches every so often.
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 150 == 0) begin
				steady = ($urandom_range(0, 3) == 0);
			end
			foreach (lanes[k]) begin
				lanes[k] = draw_voice();
			end
			w = pack_word(draw_mask(), lanes);
			send_word(w);
		end
		samples.valid = 1'b0;

		// Drain what is still owed, then give the two pipeline stages time to show any
		// stray word.
		while (board.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("drove %0d sample words (directed rails, lone speakers, lane-order clipping,",
			board.words_in);
		$display("then random masks and voices); checked %0d mix words, %0d faults",
			board.words_checked, board.failures);
		if (board.failures == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Abort a hung run well past the slowest legal one.
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

[sim.f]
+incdir+sv
sv/mmix_pkg.sv
sv/mmix_voice_if.sv
sv/mmix_mix_if.sv
sv/mmix_core.sv
sv/mix_minus_audio_mixer.sv
test/mix_minus_audio_mixer_tb.sv
